// ===== sv/sde_pkg.sv =====
package sde_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int HASH_WORDS  = 8;
  localparam int ROUNDS      = 64;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_AW     = 4;
  localparam int FILL_W      = 4;
  localparam int COUNT_W     = 33;

  localparam logic [3:0] LEN_HI_FILL = 4'd14;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        too_long;
    logic        last_word;
  } out_word_t;

  typedef struct packed {
    logic [31:0] word;
    logic        fin;
    logic        too_long;
  } blk_word_t;

  typedef struct packed {
    logic      valid;
    blk_word_t entry;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== sv/sde_front.sv =====
module sde_front
  import sde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_word_t    in_data,
  input  logic [31:0] max_bytes,
  input  fifo_stat_t  stat,
  output logic        busy,
  output push_t       push
);

  localparam logic [2:0] FS_IDLE   = 3'd0;
  localparam logic [2:0] FS_PAD80  = 3'd1;
  localparam logic [2:0] FS_ZERO   = 3'd2;
  localparam logic [2:0] FS_LEN_HI = 3'd3;
  localparam logic [2:0] FS_LEN_LO = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               tl_r, tl_nxt;

  logic               accept;
  logic [2:0]         nv_eff;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] count_sat;
  logic [FILL_W-1:0]  fill_inc;
  logic [31:0]        last_word;

  function automatic logic [31:0] merge_pad(input logic [31:0] d, input logic [2:0] nv);
    logic [31:0] w;
    case (nv)
      3'd0:    w = 32'h8000_0000;
      3'd1:    w = {d[31:24], 8'h80, 16'h0000};
      3'd2:    w = {d[31:16], 8'h80, 8'h00};
      3'd3:    w = {d[31:8], 8'h80};
      default: w = d;
    endcase
    return w;
  endfunction

  assign busy     = (state_r != FS_IDLE) || stat.full;
  assign accept   = start && !busy;
  assign nv_eff   = (!in_data.last || in_data.valid_bytes > 3'd4) ? 3'd4
                                                                  : in_data.valid_bytes;
  assign sum       = {1'b0, count_r} + (COUNT_W + 1)'(nv_eff);
  assign count_sat = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
  assign fill_inc  = fill_r + FILL_W'(1);
  assign last_word = merge_pad(in_data.data_word, nv_eff);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    fill_nxt   = fill_r;
    tl_nxt     = tl_r;
    push.valid = 1'b0;
    push.entry = '0;
    unique case (state_r)
      FS_IDLE: begin
        if (accept) begin
          push.valid      = 1'b1;
          push.entry.word = last_word;
          count_nxt       = count_sat;
          fill_nxt        = fill_inc;
          if (in_data.last) begin
            tl_nxt = count_sat > {1'b0, max_bytes};
            if (nv_eff == 3'd4) begin
              state_nxt = FS_PAD80;
            end else if (fill_inc == LEN_HI_FILL) begin
              state_nxt = FS_LEN_HI;
            end else begin
              state_nxt = FS_ZERO;
            end
          end
        end
      end
      FS_PAD80: begin
        if (!stat.full) begin
          push.valid      = 1'b1;
          push.entry.word = 32'h8000_0000;
          fill_nxt        = fill_inc;
          state_nxt       = (fill_inc == LEN_HI_FILL) ? FS_LEN_HI : FS_ZERO;
        end
      end
      FS_ZERO: begin
        if (!stat.full) begin
          push.valid = 1'b1;
          fill_nxt   = fill_inc;
          if (fill_inc == LEN_HI_FILL) begin
            state_nxt = FS_LEN_HI;
          end
        end
      end
      FS_LEN_HI: begin
        if (!stat.full) begin
          push.valid      = 1'b1;
          push.entry.word = 32'(count_r[COUNT_W-1:29]);
          fill_nxt        = fill_inc;
          state_nxt       = FS_LEN_LO;
        end
      end
      FS_LEN_LO: begin
        if (!stat.full) begin
          push.valid          = 1'b1;
          push.entry.word     = {count_r[28:0], 3'b000};
          push.entry.fin      = 1'b1;
          push.entry.too_long = tl_r;
          fill_nxt            = '0;
          count_nxt           = '0;
          tl_nxt              = 1'b0;
          state_nxt           = FS_IDLE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      count_r <= '0;
      fill_r  <= '0;
      tl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      fill_r  <= fill_nxt;
      tl_r    <= tl_nxt;
    end
  end

endmodule

// ===== sv/sde_fifo.sv =====
module sde_fifo
  import sde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       pop,
  output fifo_stat_t stat,
  output blk_word_t  head
);

  blk_word_t          mem_r [FIFO_DEPTH];
  blk_word_t          head_r;
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = head_r;
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + (FIFO_AW + 1)'(1);
      2'b01:   count_nxt = count_r - (FIFO_AW + 1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
    if (do_push && wr_ptr_r == rd_ptr_nxt) begin
      head_r <= push.entry;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/sde_back.sv =====
module sde_back
  import sde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_stat_t stat,
  input  blk_word_t  head,
  output logic       pop,
  output logic       out_strobe,
  output out_word_t  out_data
);

  localparam logic [1:0] BS_LOAD  = 2'd0;
  localparam logic [1:0] BS_ROUND = 2'd1;
  localparam logic [1:0] BS_FINAL = 2'd2;
  localparam logic [1:0] BS_OUT   = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic        tl_r, tl_nxt;
  logic        strobe_r, strobe_nxt;
  out_word_t   out_r, out_nxt;
  logic [31:0] win_r [BLOCK_WORDS];
  logic [31:0] win_nxt [BLOCK_WORDS];
  logic [31:0] v_r [HASH_WORDS];
  logic [31:0] v_nxt [HASH_WORDS];
  logic [31:0] h_r [HASH_WORDS];
  logic [31:0] h_nxt [HASH_WORDS];

  logic [31:0] t1, t2, new_w;

  assign pop        = (state_r == BS_LOAD) && !stat.empty;
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  assign t1 = v_r[7] + big_sigma1(v_r[4]) + choose(v_r[4], v_r[5], v_r[6])
            + ROUND_K[cnt_r] + win_r[0];
  assign t2 = big_sigma0(v_r[0]) + majority(v_r[0], v_r[1], v_r[2]);
  assign new_w = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    tl_nxt     = tl_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    win_nxt    = win_r;
    v_nxt      = v_r;
    h_nxt      = h_r;
    unique case (state_r)
      BS_LOAD: begin
        if (pop) begin
          for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[BLOCK_WORDS-1] = head.word;
          if (cnt_r[3:0] == 4'd15) begin
            v_nxt     = h_r;
            fin_nxt   = head.fin;
            tl_nxt    = head.too_long;
            cnt_nxt   = '0;
            state_nxt = BS_ROUND;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end
      BS_ROUND: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[BLOCK_WORDS-1] = new_w;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'(ROUNDS - 1)) begin
          state_nxt = BS_FINAL;
        end
      end
      BS_FINAL: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        cnt_nxt   = '0;
        state_nxt = fin_r ? BS_OUT : BS_LOAD;
      end
      BS_OUT: begin
        strobe_nxt = 1'b1;
        if (tl_r) begin
          out_nxt   = '{digest_word: '0, word_index: '0, too_long: 1'b1, last_word: 1'b1};
          h_nxt     = INIT_H;
          fin_nxt   = 1'b0;
          tl_nxt    = 1'b0;
          cnt_nxt   = '0;
          state_nxt = BS_LOAD;
        end else begin
          out_nxt.digest_word = h_r[0];
          out_nxt.word_index  = cnt_r[2:0];
          out_nxt.too_long    = 1'b0;
          out_nxt.last_word   = (cnt_r[2:0] == 3'd7);
          for (int i = 0; i < HASH_WORDS - 1; i++) begin
            h_nxt[i] = h_r[i+1];
          end
          h_nxt[HASH_WORDS-1] = h_r[0];
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r[2:0] == 3'd7) begin
            h_nxt     = INIT_H;
            fin_nxt   = 1'b0;
            cnt_nxt   = '0;
            state_nxt = BS_LOAD;
          end
        end
      end
      default: state_nxt = BS_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    v_r   <= v_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_LOAD;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      tl_r     <= 1'b0;
      strobe_r <= 1'b0;
      h_r      <= INIT_H;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      tl_r     <= tl_nxt;
      strobe_r <= strobe_nxt;
      h_r      <= h_nxt;
    end
  end

  a_strobe_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(state_r) == BS_OUT)
    else $error("result strobe without output state");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && out_r.too_long) |-> (out_r.last_word && out_r.digest_word == '0))
    else $error("error result malformed");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_ROUND && cnt_r == 6'(ROUNDS - 1)) |=> state_r == BS_FINAL)
    else $error("round count overran");

  a_out_needs_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BS_OUT |-> fin_r)
    else $error("output without final block");

endmodule

// ===== sv/sha256_digest_engine.sv =====
// SHA-256 engine with built-in message padding.
// Input: drive in_data with start high; a word is taken at a rising edge with
// start high and busy low. Every word carries four bytes, big-endian, except
// the one marked last, which carries 0 to 4 valid leading bytes.
// Config: cfg_we writes cfg_wdata into the maximum message length in bytes
// (reset 0xFFFFFFFF); write only while no message is in flight.
// Output: out_strobe marks a result for one cycle; it cannot be held off.
// A good message yields eight digest words on consecutive cycles,
// word 0 first, last_word on the eighth; an over-long one yields one result
// with too_long set and digest_word zero.
// The compression core loads each 64-byte block of 16 words from the queue,
// runs the rounds on it and then adds the result into the chaining hash.
// A 16-entry queue lets the input side keep taking words while a block is
// compressed; busy rises while it is full and while padding words are queued
// after the last word. Reset clears the control state and restores the
// initial hash; data registers are not reset, and no clearing pass is needed.
module sha256_digest_engine
  import sde_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_data,
  output logic        out_strobe,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] max_bytes_r, max_bytes_nxt;
  push_t       push;
  fifo_stat_t  stat;
  blk_word_t   head;
  logic        pop;

  assign max_bytes_nxt = cfg_we ? cfg_wdata : max_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= 32'hFFFF_FFFF;
    end else begin
      max_bytes_r <= max_bytes_nxt;
    end
  end

  sde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .max_bytes (max_bytes_r),
    .stat      (stat),
    .busy      (busy),
    .push      (push)
  );

  sde_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat),
    .head  (head)
  );

  sde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== dv/sha256_digest_engine_tb.sv =====
`timescale 1ns / 1ps

module sha256_digest_engine_tb;
  import sde_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int QUIET_CYCLES = 120;
  localparam logic [33:0] COUNT_CAP = 34'h1_FFFF_FFFF;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_word_t    in_data = '0;
  logic        out_strobe;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  sha256_digest_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  in_word_t    msg_word_q[$];
  out_word_t   digest_q[$];

  logic [31:0] hash_h [8];
  logic [31:0] sched_w [16];
  logic [3:0]  fill_cnt;
  logic [32:0] msg_bytes;
  logic [31:0] max_bytes;

  int unsigned cycle_cnt = 0;
  int          fails = 0;
  int          words_sent = 0;
  int          msg_cnt = 0;
  int          digest_cnt = 0;
  int          reject_cnt = 0;
  int          cfg_writes = 0;
  int          result_cnt = 0;
  bit          idle_en = 1'b1;
  int          gap_left = 0;
  int          calm_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  task automatic clear_hash_state();
    hash_h = SHA_H0;
    foreach (sched_w[i]) sched_w[i] = '0;
    fill_cnt = '0;
    msg_bytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] a, b, t1, t2;
    int t;
    v = hash_h;
    for (t = 0; t < 64; t++) begin
      if (t >= 16) begin
        a = sched_w[(t - 15) & 15];
        b = sched_w[(t - 2) & 15];
        sched_w[t & 15] = sched_w[t & 15] + (ror32(a, 7) ^ ror32(a, 18) ^ (a >> 3))
                          + sched_w[(t - 7) & 15]
                          + (ror32(b, 17) ^ ror32(b, 19) ^ (b >> 10));
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + sched_w[t & 15];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++) hash_h[t] = hash_h[t] + v[t];
  endtask

  task automatic absorb_word(input logic [31:0] w);
    sched_w[fill_cnt] = w;
    fill_cnt = fill_cnt + 4'd1;
    if (fill_cnt == 4'd0) compress_block();
  endtask

  task automatic hash_message_word(input in_word_t it);
    int nb;
    logic [33:0] sum;
    logic [31:0] keep;
    out_word_t r;
    nb = (!it.last || it.valid_bytes > 3'd4) ? 4 : int'(it.valid_bytes);
    sum = {1'b0, msg_bytes} + 34'(nb);
    msg_bytes = (sum > COUNT_CAP) ? COUNT_CAP[32:0] : sum[32:0];
    if (!it.last) begin
      absorb_word(it.data_word);
      return;
    end
    if (nb < 4) begin
      keep = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
      absorb_word((it.data_word & keep) | (32'h80 << (24 - 8 * nb)));
    end else begin
      absorb_word(it.data_word);
      absorb_word(32'h8000_0000);
    end
    while (fill_cnt != LEN_HI_FILL) absorb_word(32'h0);
    absorb_word({28'd0, msg_bytes[32:29]});
    absorb_word({msg_bytes[28:0], 3'b000});
    msg_cnt++;
    if (msg_bytes > {1'b0, max_bytes}) begin
      r = '0;
      r.too_long = 1'b1;
      r.last_word = 1'b1;
      digest_q.insert(digest_q.size(), r);
      reject_cnt++;
    end else begin
      for (int i = 0; i < 8; i++) begin
        r = '0;
        r.digest_word = hash_h[i];
        r.word_index = 3'(i);
        r.last_word = (i == 7);
        digest_q.insert(digest_q.size(), r);
      end
      digest_cnt++;
    end
    clear_hash_state();
  endtask

  function automatic void add_word(input logic [31:0] d, input logic [2:0] vb,
                                   input logic lst);
    in_word_t w;
    w.data_word = d;
    w.valid_bytes = vb;
    w.last = lst;
    msg_word_q.insert(msg_word_q.size(), w);
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_message(input int n, input logic [2:0] last_vb);
    for (int i = 0; i < n - 1; i++) add_word(pick_data(), 3'($urandom_range(0, 7)), 1'b0);
    add_word(pick_data(), last_vb, 1'b1);
  endfunction

  function automatic void add_random_messages(input int target);
    int queued;
    int n;
    queued = 0;
    while (queued < target) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      add_message(n, 3'($urandom_range(0, 7)));
      queued += n;
    end
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (msg_word_q.size() != 0 || start || digest_q.size() != 0 || busy);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_bytes(input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_bytes = v;
    cfg_writes++;
  endtask

  always @(posedge clk) begin : sender
    logic take;
    take = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        hash_message_word(in_data);
        words_sent++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (msg_word_q.size() != 0) begin
          if (calm_left > 0) calm_left--;
          else if (idle_en && $urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 40);
          if (idle_en && calm_left == 0 && $urandom_range(0, 3) == 0) gap_left = $urandom_range(0, 6);
          else take = 1'b1;
        end
        if (take) begin
          in_data <= msg_word_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    out_word_t want;
    if (rst_n && out_strobe) begin
      result_cnt++;
      if (digest_q.size() == 0) begin
        $error("result with nothing pending: %h", out_data);
        fails++;
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, out_data.digest_word);
          fails++;
        end
        if (out_data.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, out_data.word_index);
          fails++;
        end
        if (out_data.too_long !== want.too_long) begin
          $error("too_long: expected %b, got %b", want.too_long, out_data.too_long);
          fails++;
        end
        if (out_data.last_word !== want.last_word) begin
          $error("last_word: expected %b, got %b", want.last_word, out_data.last_word);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d with %0d results outstanding", cycle_cnt, digest_q.size());
      $display("** sha256_digest_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    max_bytes = 32'hFFFF_FFFF;
    clear_hash_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_word(32'h0000_0000, 3'd0, 1'b1);
    add_word(32'h6162_63FF, 3'd3, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    add_word(32'hFFFF_FFFF, 3'd2, 1'b1);
    add_word(32'h0000_0000, 3'd5, 1'b1);
    add_word(32'h1234_5678, 3'd6, 1'b1);
    add_word(32'hA5A5_A5A5, 3'd0, 1'b0);
    add_word(32'h5A5A_5A5A, 3'd2, 1'b1);
    for (int i = 0; i < 13; i++) add_word($urandom, 3'(i % 8), 1'b0);
    add_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    wait_quiet();

    write_max_bytes(32'h8000_0000 | $urandom);
    add_random_messages(45);
    wait_quiet();

    write_max_bytes(32'h0);
    add_random_messages(25);
    wait_quiet();

    // hold the limit right at a message length
    write_max_bytes(32'd12);
    add_message(3, 3'd4);
    add_message(4, 3'd1);
    add_message(4, 3'd0);
    wait_quiet();

    write_max_bytes(32'($urandom_range(1, 100)));
    add_random_messages(45);
    wait_quiet();

    idle_en = 1'b0;
    write_max_bytes(32'hFFFF_FFFF);
    add_random_messages(45);
    wait_quiet();

    $display("sent %0d words in %0d messages: %0d digests and %0d length rejections checked",
             words_sent, msg_cnt, digest_cnt, reject_cnt);
    $display("%0d result words compared over %0d length limit settings", result_cnt,
             cfg_writes + 1);
    if (fails == 0) begin
      $display("** sha256_digest_engine: PASSED **");
    end else begin
      $display("** sha256_digest_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sde_pkg.sv
sv/sde_front.sv
sv/sde_fifo.sv
sv/sde_back.sv
sv/sha256_digest_engine.sv
dv/sha256_digest_engine_tb.sv
